[sv/cspr_pkg.sv]
// cspr_pkg: shared types and constants of the circular successor pick/remove block
// no dependencies; imported by the cell chain, the interfaces and the top level
`default_nettype none

package cspr_pkg;

  // fixed field widths
  localparam int VAL_W = 10;
  localparam int MOD_W = 11;
  localparam int CNT_W = 11;
  localparam int STAT_W = 2;

  // internal residue index, wide enough for any start point below the modulus
  localparam int IDX_W = 11;

  // residues held by one cell of the chain
  localparam int GRP_W = 32;
  localparam int OFF_W = 5;
  localparam int CELL_W = IDX_W - OFF_W;

  // number of residues that a value field can name
  localparam int VAL_RANGE = 1 << VAL_W;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 11'd1024;
  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // search bounds broadcast to every cell
  typedef struct packed {
    logic [IDX_W-1:0] lo0;  // first pass runs over [lo0, hi0)
    logic [IDX_W-1:0] hi0;
    logic [IDX_W-1:0] hi1;  // wrapped pass runs over [0, hi1)
  } srch_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic pass;
  } tok_t;

  // token injection at the cell that holds the start residue
  typedef struct packed {
    logic              valid;
    logic              pass;
    logic [CELL_W-1:0] grp;
  } inj_t;

  // occupancy bit update
  typedef struct packed {
    logic             en;
    logic             set;
    logic [IDX_W-1:0] idx;
  } occ_wr_t;

  // search response of one cell
  typedef struct packed {
    logic             hit;
    logic             miss;
    logic [IDX_W-1:0] idx;
  } hit_t;

endpackage

`default_nettype wire

[sv/cspr_chan_if.sv]
// cspr_chan_if: valid/ready channel interfaces for input items, results and configuration
// depends on cspr_pkg for the field widths
`default_nettype none

interface cspr_in_if import cspr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [VAL_W-1:0] value;
  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface cspr_out_if import cspr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  sum_mod;
  logic [STAT_W-1:0] status;
  modport source (output valid, output sum_mod, output status, input ready);
  modport sink (input valid, input sum_mod, input status, output ready);
endinterface

interface cspr_cfg_if import cspr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] modulus;
  modport source (output valid, output modulus, input ready);
  modport sink (input valid, input modulus, output ready);
endinterface

`default_nettype wire

[sv/cspr_ram.sv]
// cspr_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cspr_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/cspr_cell.sv]
// cspr_cell: one link of the search chain, holding the occupancy bits of a group of residues
// depends on cspr_pkg
`default_nettype none

module cspr_cell import cspr_pkg::*; #(
  parameter int CELL_IDX = 0,
  parameter bit IS_LAST = 1'b0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire occ_wr_t occ_wr,
  input  wire inj_t    inj,
  input  wire tok_t    tok_in,
  input  wire srch_t   srch,
  output tok_t         tok_out,
  output hit_t         resp
);

  localparam logic [IDX_W-1:0] BASE = IDX_W'(CELL_IDX * GRP_W);
  localparam logic [CELL_W-1:0] MY_CELL = CELL_W'(CELL_IDX);

  logic [GRP_W-1:0] occ_r, occ_nxt;
  tok_t             tok_r, tok_nxt;

  logic [IDX_W-1:0] lo, hi, g;
  logic [GRP_W-1:0] in_rng, m, low;
  logic [OFF_W-1:0] off;
  logic             found, last_grp;

  // occupancy update
  always_comb begin
    occ_nxt = occ_r;
    if (occ_wr.en && occ_wr.idx[IDX_W-1:OFF_W] == MY_CELL) begin
      occ_nxt[occ_wr.idx[OFF_W-1:0]] = occ_wr.set;
    end
  end

  // local search over the bits inside the current pass range
  always_comb begin
    lo = tok_r.pass ? '0 : srch.lo0;
    hi = tok_r.pass ? srch.hi1 : srch.hi0;
    for (int j = 0; j < GRP_W; j++) begin
      g = BASE + IDX_W'(j);
      in_rng[j] = (g >= lo) && (g < hi);
    end
    m = occ_r & in_rng;
    low = m & (~m + 1'b1);
    off = '0;
    for (int j = 0; j < GRP_W; j++) begin
      if (low[j]) begin
        off = off | OFF_W'(j);
      end
    end
    found = |m;
    last_grp = ({1'b0, BASE} + (IDX_W + 1)'(GRP_W)) >= {1'b0, srch.hi1};
  end

  always_comb begin
    resp.hit = tok_r.valid && found;
    resp.miss = tok_r.valid && !found && tok_r.pass && last_grp;
    resp.idx = resp.hit ? {MY_CELL, off} : '0;
    tok_out.valid = tok_r.valid && !found && !(tok_r.pass && last_grp);
    tok_out.pass = tok_r.pass | IS_LAST;
  end

  always_comb begin
    if (inj.valid && inj.grp == MY_CELL) begin
      tok_nxt.valid = 1'b1;
      tok_nxt.pass = inj.pass;
    end else begin
      tok_nxt = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      tok_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      tok_r <= tok_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/circular_successor_pick_remove.sv]
// circular_successor_pick_remove: top level, count store, sequencer and the ring of search cells
// depends on cspr_pkg, cspr_chan_if, cspr_ram and cspr_cell
`default_nettype none

// Keeps a multiset of residues modulo the configured modulus. A load adds one
// copy of a residue (ignored at or above the modulus, saturating at 2047
// copies) and gives no result. A query with value a returns (a+b) mod n for the
// first occupied residue b at or after (n-a) mod n with wraparound, removes one
// copy of b and reports ok; an empty set gives status empty, a query value at or
// above the modulus gives status range, both with sum 0. Counts live in a ram;
// occupancy bits live in a ring of cells of 32 residues each, and a query walks
// a token around that ring one cell per cycle. After reset the block clears
// every entry of the count ram before it takes an item; configuration transfers
// are taken at any time. How long a query takes is set by how far the token
// travels from the start cell; its result then moves into the output register.
// The output register lets the next item start while a result waits.
module circular_successor_pick_remove import cspr_pkg::*; #(
  parameter int MAX_MODULUS = 1024
) (
  input wire logic clk,
  input wire logic rst_n,
  cspr_in_if.sink    in_ch,
  cspr_out_if.source out_ch,
  cspr_cfg_if.sink   cfg_ch
);

  // stored residues never exceed what the value field can name
  localparam int DEPTH = (MAX_MODULUS < VAL_RANGE) ? MAX_MODULUS : VAL_RANGE;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NCELL = (DEPTH + GRP_W - 1) / GRP_W;

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LWR  = 3'd2;
  localparam logic [2:0] S_QINJ = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_QWR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [MOD_W-1:0] modulus_r;
  logic [MOD_W-1:0] n_eff, lim;

  // item and search context
  logic [VAL_W-1:0] v_r, v_nxt;
  logic [IDX_W-1:0] s_r, s_nxt;
  logic [IDX_W-1:0] hi1_r, hi1_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [IDX_W-1:0] s_calc;

  // pending result and output register
  logic [VAL_W-1:0]  res_sum_r, res_sum_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_sum_r, out_sum_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;

  // count ram
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;

  // cell ring
  srch_t   srch;
  inj_t    inj;
  occ_wr_t occ_wr;
  tok_t    tok_out [NCELL];
  hit_t    resp [NCELL];
  logic             any_hit, any_miss;
  logic [IDX_W-1:0] hit_idx;

  logic             in_xfer;
  logic             out_free;
  logic [IDX_W:0]   sum_full;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // modulus in use: zero acts as one, clamp to the largest supported modulus
  always_comb begin
    n_eff = modulus_r;
    if (modulus_r == '0) begin
      n_eff = MOD_W'(1);
    end else if ({21'b0, modulus_r} > 32'(MAX_MODULUS)) begin
      n_eff = MOD_W'(MAX_MODULUS);
    end
    lim = (n_eff < MOD_W'(DEPTH)) ? n_eff : MOD_W'(DEPTH);
  end

  // start residue (n - a) mod n for a query value below n
  assign s_calc = (in_ch.value == '0) ? '0 : (n_eff - {1'b0, in_ch.value});

  // reduce the cell responses; at most one cell holds the token
  always_comb begin
    any_hit = 1'b0;
    any_miss = 1'b0;
    hit_idx = '0;
    for (int c = 0; c < NCELL; c++) begin
      any_hit = any_hit | resp[c].hit;
      any_miss = any_miss | resp[c].miss;
      hit_idx = hit_idx | resp[c].idx;
    end
  end

  assign srch.lo0 = s_r;
  assign srch.hi0 = lim;
  assign srch.hi1 = hi1_r;

  // (a + b) mod n with a, b below n
  always_comb begin
    sum_full = {2'b0, v_r} + {1'b0, hit_idx_r};
    if (sum_full >= {1'b0, n_eff}) begin
      sum_full = sum_full - {1'b0, n_eff};
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    v_nxt = v_r;
    s_nxt = s_r;
    hi1_nxt = hi1_r;
    hit_idx_nxt = hit_idx_r;
    clr_nxt = clr_r;
    res_sum_nxt = res_sum_r;
    res_stat_nxt = res_stat_r;
    ram_we = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    ram_raddr = hit_idx[AW-1:0];
    inj = '0;
    occ_wr = '0;

    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // the count of a loaded residue is read as it is accepted
        ram_raddr = in_ch.value[AW-1:0];
        if (in_xfer) begin
          v_nxt = in_ch.value;
          if ({1'b0, in_ch.value} >= n_eff) begin
            if (in_ch.mode == MODE_QUERY) begin
              res_sum_nxt = '0;
              res_stat_nxt = STAT_RANGE;
              state_nxt = S_DONE;
            end
          end else if (in_ch.mode == MODE_LOAD) begin
            state_nxt = S_LWR;
          end else begin
            s_nxt = s_calc;
            hi1_nxt = (s_calc < lim) ? s_calc : lim;
            state_nxt = S_QINJ;
          end
        end
      end

      S_LWR: begin
        ram_waddr = v_r[AW-1:0];
        ram_wdata = ram_rdata + 1'b1;
        ram_we = (ram_rdata != COUNT_MAX);
        occ_wr.en = 1'b1;
        occ_wr.set = 1'b1;
        occ_wr.idx = IDX_W'(v_r);
        state_nxt = S_IDLE;
      end

      S_QINJ: begin
        // start in the cell of the start residue, or go straight to the wrapped pass
        inj.valid = 1'b1;
        if (s_r < lim) begin
          inj.pass = 1'b0;
          inj.grp = s_r[IDX_W-1:OFF_W];
        end else begin
          inj.pass = 1'b1;
          inj.grp = '0;
        end
        state_nxt = S_SRCH;
      end

      S_SRCH: begin
        if (any_hit) begin
          hit_idx_nxt = hit_idx;
          state_nxt = S_QWR;
        end else if (any_miss) begin
          res_sum_nxt = '0;
          res_stat_nxt = STAT_EMPTY;
          state_nxt = S_DONE;
        end
      end

      S_QWR: begin
        // remove one copy; clear the occupancy bit on the last one
        ram_waddr = hit_idx_r[AW-1:0];
        ram_wdata = ram_rdata - 1'b1;
        ram_we = 1'b1;
        occ_wr.en = (ram_rdata == CNT_W'(1));
        occ_wr.set = 1'b0;
        occ_wr.idx = hit_idx_r;
        res_sum_nxt = sum_full[VAL_W-1:0];
        res_stat_nxt = STAT_OK;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sum_nxt = out_sum_r;
    out_stat_nxt = out_stat_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt = res_sum_r;
      out_stat_nxt = res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      modulus_r <= MODULUS_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        modulus_r <= cfg_ch.modulus;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    s_r <= s_nxt;
    hi1_r <= hi1_nxt;
    hit_idx_r <= hit_idx_nxt;
    res_sum_r <= res_sum_nxt;
    res_stat_r <= res_stat_nxt;
    out_sum_r <= out_sum_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.sum_mod = out_sum_r;
  assign out_ch.status = out_stat_r;

  // residue counts
  cspr_ram #(
    .WIDTH(CNT_W),
    .DEPTH(DEPTH)
  ) u_counts (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (1'b1),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // ring of search cells; the last cell hands the token back to the first
  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    cspr_cell #(
      .CELL_IDX(c),
      .IS_LAST (c == NCELL - 1)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .occ_wr (occ_wr),
      .inj    (inj),
      .tok_in (tok_out[(c + NCELL - 1) % NCELL]),
      .srch   (srch),
      .tok_out(tok_out[c]),
      .resp   (resp[c])
    );
  end

endmodule

`default_nettype wire
